[design/ptbv_pkg.sv]
// ----------------------------------------------------------------------------
// ptbv_pkg
// Shared types, constants and the microcode program for the pose to body
// velocity core.
// ----------------------------------------------------------------------------
package ptbv_pkg;

	// Fixed-point constants.
	localparam logic signed [39:0] Q30_ONE   = 40'sd1073741824;
	localparam logic signed [31:0] NS_PER_S  = 32'sd1000000000;
	localparam logic signed [31:0] RATE_MUL  = 32'sd1953125;
	localparam logic [31:0]        MIN_RESET = 32'd100000;
	localparam logic [31:0]        MAX_RESET = 32'd500000000;

	// Widths of the arithmetic path.
	localparam int A_W    = 36;
	localparam int B_W    = 32;
	localparam int PROD_W = A_W + B_W;
	localparam int ACC_W  = 38;
	localparam int DIV_W  = 36;

	// Microcode program.
	localparam int          PROG_LEN = 49;
	localparam int          PC_W     = 6;
	localparam logic [3:0]  I_X      = 4'd0;
	localparam logic [3:0]  I_Y      = 4'd1;
	localparam logic [3:0]  I_Z      = 4'd2;
	localparam logic [3:0]  I_W      = 4'd3;

	// Configuration register indexes.
	localparam logic REG_MIN = 1'b0;
	localparam logic REG_MAX = 1'b1;

	typedef struct packed {
		logic              body_present;
		logic [63:0]       stamp_ns;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_w;
	} pose_t;

	typedef struct packed {
		logic              twist_valid;
		logic signed [31:0] lin_vel_x;
		logic signed [31:0] lin_vel_y;
		logic signed [31:0] lin_vel_z;
		logic signed [31:0] ang_vel_x;
		logic signed [31:0] ang_vel_y;
		logic signed [31:0] ang_vel_z;
	} twist_t;

	// Multiplier operand A sources.
	typedef enum logic [2:0] {
		AG_Q,
		AG_CONJ,
		AG_DP,
		AG_DQ,
		AG_R
	} a_grp_t;

	// Multiplier operand B sources.
	typedef enum logic [1:0] {
		BG_Q,
		BG_V,
		BG_NS,
		BG_RATE
	} b_grp_t;

	// What the accumulate stage does with a product.
	typedef enum logic [2:0] {
		WM_NONE,
		WM_TWICE,
		WM_ONE_MINUS,
		WM_SAT,
		WM_SIGN,
		WM_DQ,
		WM_DIV_LIN,
		WM_DIV_ANG
	} wmode_t;

	typedef struct packed {
		a_grp_t     a_grp;
		logic [3:0] a_idx;
		b_grp_t     b_grp;
		logic [3:0] b_idx;
		logic       first;
		logic       neg;
		wmode_t     wmode;
		logic [3:0] d_idx;
	} uop_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic check;
		logic issue;
		logic finish;
		uop_t uop;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic valid;
		logic div_done;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
		logic signed [31:0] r;
		if (x > 40'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic uop_t mk(input a_grp_t ag, input logic [3:0] ai, input b_grp_t bg,
			input logic [3:0] bi, input logic f, input logic n, input wmode_t wm,
			input logic [3:0] d);
		uop_t u;
		u.a_grp = ag;
		u.a_idx = ai;
		u.b_grp = bg;
		u.b_idx = bi;
		u.first = f;
		u.neg   = n;
		u.wmode = wm;
		u.d_idx = d;
		return u;
	endfunction

	// The program: world velocity divisions, rotation matrix, body-frame
	// velocity, rotation increment and angular rate divisions.
	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = mk(AG_Q, I_X, BG_Q, I_X, 1'b1, 1'b0, WM_NONE, 4'd0);
		unique case (pc)
			6'd0:  u = mk(AG_DP, 4'd0, BG_NS, I_X, 1'b1, 1'b0, WM_DIV_LIN, 4'd0);
			6'd1:  u = mk(AG_DP, 4'd1, BG_NS, I_X, 1'b1, 1'b0, WM_DIV_LIN, 4'd1);
			6'd2:  u = mk(AG_DP, 4'd2, BG_NS, I_X, 1'b1, 1'b0, WM_DIV_LIN, 4'd2);
			6'd3:  u = mk(AG_Q, I_Y, BG_Q, I_Y, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd4:  u = mk(AG_Q, I_Z, BG_Q, I_Z, 1'b0, 1'b0, WM_ONE_MINUS, 4'd0);
			6'd5:  u = mk(AG_Q, I_X, BG_Q, I_Y, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd6:  u = mk(AG_Q, I_Z, BG_Q, I_W, 1'b0, 1'b1, WM_TWICE, 4'd1);
			6'd7:  u = mk(AG_Q, I_X, BG_Q, I_Z, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd8:  u = mk(AG_Q, I_Y, BG_Q, I_W, 1'b0, 1'b0, WM_TWICE, 4'd2);
			6'd9:  u = mk(AG_Q, I_X, BG_Q, I_Y, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd10: u = mk(AG_Q, I_Z, BG_Q, I_W, 1'b0, 1'b0, WM_TWICE, 4'd3);
			6'd11: u = mk(AG_Q, I_X, BG_Q, I_X, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd12: u = mk(AG_Q, I_Z, BG_Q, I_Z, 1'b0, 1'b0, WM_ONE_MINUS, 4'd4);
			6'd13: u = mk(AG_Q, I_Y, BG_Q, I_Z, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd14: u = mk(AG_Q, I_X, BG_Q, I_W, 1'b0, 1'b1, WM_TWICE, 4'd5);
			6'd15: u = mk(AG_Q, I_X, BG_Q, I_Z, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd16: u = mk(AG_Q, I_Y, BG_Q, I_W, 1'b0, 1'b1, WM_TWICE, 4'd6);
			6'd17: u = mk(AG_Q, I_Y, BG_Q, I_Z, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd18: u = mk(AG_Q, I_X, BG_Q, I_W, 1'b0, 1'b0, WM_TWICE, 4'd7);
			6'd19: u = mk(AG_Q, I_X, BG_Q, I_X, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd20: u = mk(AG_Q, I_Y, BG_Q, I_Y, 1'b0, 1'b0, WM_ONE_MINUS, 4'd8);
			6'd21: u = mk(AG_R, 4'd0, BG_V, 4'd0, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd22: u = mk(AG_R, 4'd3, BG_V, 4'd1, 1'b0, 1'b0, WM_NONE, 4'd0);
			6'd23: u = mk(AG_R, 4'd6, BG_V, 4'd2, 1'b0, 1'b0, WM_SAT, 4'd0);
			6'd24: u = mk(AG_R, 4'd1, BG_V, 4'd0, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd25: u = mk(AG_R, 4'd4, BG_V, 4'd1, 1'b0, 1'b0, WM_NONE, 4'd0);
			6'd26: u = mk(AG_R, 4'd7, BG_V, 4'd2, 1'b0, 1'b0, WM_SAT, 4'd1);
			6'd27: u = mk(AG_R, 4'd2, BG_V, 4'd0, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd28: u = mk(AG_R, 4'd5, BG_V, 4'd1, 1'b0, 1'b0, WM_NONE, 4'd0);
			6'd29: u = mk(AG_R, 4'd8, BG_V, 4'd2, 1'b0, 1'b0, WM_SAT, 4'd2);
			6'd30: u = mk(AG_CONJ, I_W, BG_Q, I_W, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd31: u = mk(AG_CONJ, I_X, BG_Q, I_X, 1'b0, 1'b1, WM_NONE, 4'd0);
			6'd32: u = mk(AG_CONJ, I_Y, BG_Q, I_Y, 1'b0, 1'b1, WM_NONE, 4'd0);
			6'd33: u = mk(AG_CONJ, I_Z, BG_Q, I_Z, 1'b0, 1'b1, WM_SIGN, 4'd0);
			6'd34: u = mk(AG_CONJ, I_W, BG_Q, I_X, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd35: u = mk(AG_CONJ, I_X, BG_Q, I_W, 1'b0, 1'b0, WM_NONE, 4'd0);
			6'd36: u = mk(AG_CONJ, I_Y, BG_Q, I_Z, 1'b0, 1'b0, WM_NONE, 4'd0);
			6'd37: u = mk(AG_CONJ, I_Z, BG_Q, I_Y, 1'b0, 1'b1, WM_DQ, 4'd0);
			6'd38: u = mk(AG_CONJ, I_W, BG_Q, I_Y, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd39: u = mk(AG_CONJ, I_X, BG_Q, I_Z, 1'b0, 1'b1, WM_NONE, 4'd0);
			6'd40: u = mk(AG_CONJ, I_Y, BG_Q, I_W, 1'b0, 1'b0, WM_NONE, 4'd0);
			6'd41: u = mk(AG_CONJ, I_Z, BG_Q, I_X, 1'b0, 1'b0, WM_DQ, 4'd1);
			6'd42: u = mk(AG_CONJ, I_W, BG_Q, I_Z, 1'b1, 1'b0, WM_NONE, 4'd0);
			6'd43: u = mk(AG_CONJ, I_X, BG_Q, I_Y, 1'b0, 1'b0, WM_NONE, 4'd0);
			6'd44: u = mk(AG_CONJ, I_Y, BG_Q, I_X, 1'b0, 1'b1, WM_NONE, 4'd0);
			6'd45: u = mk(AG_CONJ, I_Z, BG_Q, I_W, 1'b0, 1'b0, WM_DQ, 4'd2);
			6'd46: u = mk(AG_DQ, 4'd0, BG_RATE, I_X, 1'b1, 1'b0, WM_DIV_ANG, 4'd0);
			6'd47: u = mk(AG_DQ, 4'd1, BG_RATE, I_X, 1'b1, 1'b0, WM_DIV_ANG, 4'd1);
			6'd48: u = mk(AG_DQ, 4'd2, BG_RATE, I_X, 1'b1, 1'b0, WM_DIV_ANG, 4'd2);
			default: u = mk(AG_Q, I_X, BG_Q, I_X, 1'b1, 1'b0, WM_NONE, 4'd0);
		endcase
		return u;
	endfunction

endpackage

[design/pose_to_body_velocity_core.sv]
// ----------------------------------------------------------------------------
// pose_to_body_velocity_core
// Body-frame linear and angular velocity from successive timestamped poses.
// ----------------------------------------------------------------------------
// A pose with body_present set runs, when the interval to the previous pose is
// in range, through the check, the microcode program and the finish step before
// its result can be taken; when it is not, it goes from the check straight to
// the finish step. The program uses the shared radix-2 divider for six divisions
// (issue, start, 32 quotient steps and the hand-off each) and the shared
// multiplier for 43 further steps. A pose without body_present is taken while
// the core is idle and gives no result. The next pose is accepted while the
// previous result still waits in the output register. Configuration writes must
// be made by the user only while the core is idle; the core does not enforce it.
module pose_to_body_velocity_core import ptbv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pose_valid,
	output logic        pose_ready,
	input  pose_t       pose,
	output logic        vel_valid,
	input  logic        vel_ready,
	output twist_t      vel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] min_interval_ns;
	logic [31:0] max_interval_ns;
	cmd_t        cmd;
	stat_t       stat;

	ptbv_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.min_interval_ns (min_interval_ns),
		.max_interval_ns (max_interval_ns)
	);

	ptbv_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pose_valid   (pose_valid),
		.body_present (pose.body_present),
		.pose_ready   (pose_ready),
		.vel_valid    (vel_valid),
		.vel_ready    (vel_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	ptbv_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.pose            (pose),
		.min_interval_ns (min_interval_ns),
		.max_interval_ns (max_interval_ns),
		.cmd             (cmd),
		.stat            (stat),
		.vel             (vel)
	);

endmodule

[design/ptbv_regs.sv]
// ----------------------------------------------------------------------------
// ptbv_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module ptbv_regs import ptbv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] min_interval_ns,
	output logic [31:0] max_interval_ns
);

	logic [31:0] min_q;
	logic [31:0] max_q;
	logic        wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
			max_q <= MAX_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MIN: min_q <= pwdata;
				REG_MAX: max_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		unique case (paddr[2])
			REG_MIN: prdata = min_q;
			REG_MAX: prdata = max_q;
			default: prdata = '0;
		endcase
	end

	assign min_interval_ns = min_q;
	assign max_interval_ns = max_q;

endmodule

[design/ptbv_ctrl.sv]
// ----------------------------------------------------------------------------
// ptbv_ctrl
// Controller: sequences one pose through the check, the microcode program
// and the result register.
// ----------------------------------------------------------------------------
module ptbv_ctrl import ptbv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pose_valid,
	input  logic  body_present,
	output logic  pose_ready,
	output logic  vel_valid,
	input  logic  vel_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t          state_q;
	state_t          state_d;
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic            full_q;

	// State and program counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	// Result register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (cmd.finish) begin
			full_q <= 1'b1;
		end else if (vel_ready) begin
			full_q <= 1'b0;
		end
	end

	assign vel_valid  = full_q;
	assign pose_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		pc_d       = pc_q;
		cmd.load   = 1'b0;
		cmd.check  = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		cmd.uop    = ucode(pc_q);
		unique case (state_q)
			ST_IDLE: begin
				if (pose_valid && body_present) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				pc_d      = '0;
				state_d   = stat.valid ? ST_ISSUE : ST_FINISH;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				pc_d      = pc_q + 1'b1;
				if (cmd.uop.wmode == WM_DIV_LIN || cmd.uop.wmode == WM_DIV_ANG) begin
					state_d = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = (pc_q == PC_W'(PROG_LEN)) ? ST_FINISH : ST_ISSUE;
				end
			end
			ST_FINISH: begin
				if (!full_q || vel_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[design/ptbv_div.sv]
// ----------------------------------------------------------------------------
// ptbv_div
// Radix-2 restoring divider: signed 64-bit dividend by an unsigned divisor,
// quotient truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module ptbv_div import ptbv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic [DIV_W-1:0]   divisor,
	output logic               done,
	output logic signed [31:0] quot
);

	logic             busy_q;
	logic [4:0]       cnt_q;
	logic             done_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [31:0]      lo_q;
	logic [31:0]      quo_q;
	logic             neg_q;
	logic             ovf_q;
	logic [63:0]      mag;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign mag   = dividend[63] ? 64'(-dividend) : 64'(dividend);
	assign trial = {rem_q, lo_q[31]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle; the upper half seeds the remainder, so a
	// quotient wider than 32 bits shows as overflow right at the start.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63];
			ovf_q <= {4'b0, mag[63:32]} >= divisor;
			rem_q <= {4'b0, mag[63:32]};
			lo_q  <= mag[31:0];
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	// Sign and saturation.
	always_comb begin
		if (!neg_q) begin
			quot = (ovf_q || quo_q[31]) ? 32'sh7fffffff : quo_q;
		end else if (ovf_q || (quo_q[31] && (|quo_q[30:0]))) begin
			quot = 32'sh80000000;
		end else begin
			quot = -quo_q;
		end
	end

	assign done = done_q;

endmodule

[design/ptbv_dp.sv]
// ----------------------------------------------------------------------------
// ptbv_dp
// Datapath: held pose, interval check, shared multiplier with accumulator,
// shared divider and the result register.
// ----------------------------------------------------------------------------
module ptbv_dp import ptbv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pose_t       pose,
	input  logic [31:0] min_interval_ns,
	input  logic [31:0] max_interval_ns,
	input  cmd_t        cmd,
	output stat_t       stat,
	output twist_t      vel
);

	// Previous pose.
	logic               have_prev_q;
	logic [63:0]        prev_time_q;
	logic signed [31:0] prev_pos_q [3];
	logic signed [31:0] prev_qx_q;
	logic signed [31:0] prev_qy_q;
	logic signed [31:0] prev_qz_q;
	logic signed [31:0] prev_qw_q;

	// Current pose and interval.
	pose_t              cur_q;
	logic [63:0]        dt_q;
	logic               ge_q;
	logic               valid_q;
	logic signed [32:0] dp_q [3];

	// Working values.
	logic signed [31:0]      r_q   [9];
	logic signed [31:0]      v_q   [3];
	logic signed [31:0]      lin_q [3];
	logic signed [31:0]      ang_q [3];
	logic signed [A_W-1:0]   dq_q  [3];
	logic                    flip_q;
	logic signed [ACC_W-1:0] acc_q;

	// Multiplier stage.
	logic signed [A_W-1:0]    a_val;
	logic signed [B_W-1:0]    b_val;
	logic signed [PROD_W-1:0] prod_s1;
	uop_t                     uop_s1;
	logic                     act_s1;

	// Accumulate stage.
	logic signed [ACC_W-1:0] psh;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [39:0]      wide;
	logic signed [39:0]      twice;
	logic signed [39:0]      one_minus;

	// Divider.
	logic               div_start;
	logic [DIV_W-1:0]   div_den;
	logic               div_done;
	logic signed [31:0] div_quot;
	logic               div_ang_q;
	logic [1:0]         div_idx_q;

	twist_t             out_q;

	function automatic logic signed [31:0] qsel(input pose_t p, input logic [1:0] i);
		logic signed [31:0] r;
		case (i)
			2'd0:    r = p.quat_x;
			2'd1:    r = p.quat_y;
			2'd2:    r = p.quat_z;
			default: r = p.quat_w;
		endcase
		return r;
	endfunction

	// Interval check.
	assign stat.valid = have_prev_q && ge_q && (dt_q > {32'b0, min_interval_ns}) &&
		(dt_q < {32'b0, max_interval_ns});
	assign stat.div_done = div_done;

	// Previous pose state, replaced when a result is produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q   <= 1'b0;
			prev_time_q   <= '0;
			prev_pos_q[0] <= '0;
			prev_pos_q[1] <= '0;
			prev_pos_q[2] <= '0;
			prev_qx_q     <= '0;
			prev_qy_q     <= '0;
			prev_qz_q     <= '0;
			prev_qw_q     <= Q30_ONE[31:0];
		end else if (cmd.finish) begin
			have_prev_q   <= 1'b1;
			prev_time_q   <= cur_q.stamp_ns;
			prev_pos_q[0] <= cur_q.pos_x;
			prev_pos_q[1] <= cur_q.pos_y;
			prev_pos_q[2] <= cur_q.pos_z;
			prev_qx_q     <= cur_q.quat_x;
			prev_qy_q     <= cur_q.quat_y;
			prev_qz_q     <= cur_q.quat_z;
			prev_qw_q     <= cur_q.quat_w;
		end
	end

	// Capture the pose, the interval and the position differences.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= pose;
			dt_q  <= pose.stamp_ns - prev_time_q;
			ge_q  <= pose.stamp_ns >= prev_time_q;
			dp_q[0] <= {pose.pos_x[31], pose.pos_x} - {prev_pos_q[0][31], prev_pos_q[0]};
			dp_q[1] <= {pose.pos_y[31], pose.pos_y} - {prev_pos_q[1][31], prev_pos_q[1]};
			dp_q[2] <= {pose.pos_z[31], pose.pos_z} - {prev_pos_q[2][31], prev_pos_q[2]};
		end
		if (cmd.check) begin
			valid_q <= stat.valid;
		end
	end

	// Operand A selection.
	always_comb begin
		case (cmd.uop.a_grp)
			AG_Q: a_val = A_W'(qsel(cur_q, cmd.uop.a_idx[1:0]));
			AG_CONJ: begin
				case (cmd.uop.a_idx[1:0])
					2'd0:    a_val = -A_W'(prev_qx_q);
					2'd1:    a_val = -A_W'(prev_qy_q);
					2'd2:    a_val = -A_W'(prev_qz_q);
					default: a_val = A_W'(prev_qw_q);
				endcase
			end
			AG_DP:   a_val = A_W'(dp_q[cmd.uop.a_idx[1:0]]);
			AG_DQ:   a_val = dq_q[cmd.uop.a_idx[1:0]];
			default: a_val = A_W'(r_q[cmd.uop.a_idx]);
		endcase
	end

	// Operand B selection.
	always_comb begin
		case (cmd.uop.b_grp)
			BG_Q:    b_val = qsel(cur_q, cmd.uop.b_idx[1:0]);
			BG_V:    b_val = v_q[cmd.uop.b_idx[1:0]];
			BG_NS:   b_val = NS_PER_S;
			default: b_val = RATE_MUL;
		endcase
	end

	// Shared multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_val * b_val;
		uop_s1  <= cmd.uop;
	end

	// Accumulate the floored Q30 product and form the write-back values.
	assign psh       = prod_s1[PROD_W-1:30];
	assign term      = uop_s1.neg ? -psh : psh;
	assign acc_next  = (uop_s1.first ? '0 : acc_q) + term;
	assign wide      = 40'(acc_next);
	assign twice     = wide <<< 1;
	assign one_minus = Q30_ONE - twice;

	always_ff @(posedge clk) begin
		if (act_s1) begin
			acc_q <= acc_next;
			case (uop_s1.wmode)
				WM_TWICE:     r_q[uop_s1.d_idx] <= sat32(twice);
				WM_ONE_MINUS: r_q[uop_s1.d_idx] <= sat32(one_minus);
				WM_SAT:       lin_q[uop_s1.d_idx[1:0]] <= sat32(wide);
				WM_SIGN:      flip_q <= acc_next[ACC_W-1];
				WM_DQ: begin
					dq_q[uop_s1.d_idx[1:0]] <= flip_q ? -acc_next[A_W-1:0] :
						acc_next[A_W-1:0];
				end
				default: ;
			endcase
		end
		if (div_start) begin
			div_ang_q <= (uop_s1.wmode == WM_DIV_ANG);
			div_idx_q <= uop_s1.d_idx[1:0];
		end
		if (div_done) begin
			if (div_ang_q) begin
				ang_q[div_idx_q] <= div_quot;
			end else begin
				v_q[div_idx_q] <= div_quot;
			end
		end
	end

	// Divisions by the interval, or by sixteen times it for angular rate.
	assign div_start = act_s1 && (uop_s1.wmode == WM_DIV_LIN || uop_s1.wmode == WM_DIV_ANG);
	assign div_den   = (uop_s1.wmode == WM_DIV_ANG) ? {dt_q[31:0], 4'b0} : {4'b0, dt_q[31:0]};

	ptbv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_s1[63:0]),
		.divisor  (div_den),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (valid_q) begin
				out_q.twist_valid <= 1'b1;
				out_q.lin_vel_x   <= lin_q[0];
				out_q.lin_vel_y   <= lin_q[1];
				out_q.lin_vel_z   <= lin_q[2];
				out_q.ang_vel_x   <= ang_q[0];
				out_q.ang_vel_y   <= ang_q[1];
				out_q.ang_vel_z   <= ang_q[2];
			end else begin
				out_q <= '0;
			end
		end
	end

	assign vel = out_q;

endmodule

[design/ptbv_checker.sv]
// ----------------------------------------------------------------------------
// ptbv_checker
// Port-level checks for the pose to body velocity core.
// ----------------------------------------------------------------------------
module ptbv_checker import ptbv_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   pose_valid,
	input logic   pose_ready,
	input pose_t  pose,
	input logic   vel_valid,
	input logic   vel_ready,
	input twist_t vel
);

	// A present pose keeps the core busy for at least the next cycle.
	a_busy_after_pose: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && pose_ready && pose.body_present |=> !pose_ready)
		else $error("core ready right after taking a present pose");

	// An absent pose is dropped without occupying the core.
	a_absent_drop: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && pose_ready && !pose.body_present |=> pose_ready)
		else $error("core busy after an absent pose");

	// A zero twist carries zeros in every velocity field.
	a_zero_twist: assert property (@(posedge clk) disable iff (!arst_n)
		vel_valid && !vel.twist_valid |-> vel.lin_vel_x == 0 && vel.lin_vel_y == 0 &&
		vel.lin_vel_z == 0 && vel.ang_vel_x == 0 && vel.ang_vel_y == 0 &&
		vel.ang_vel_z == 0)
		else $error("zero twist with nonzero velocity");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vel_valid && !vel_ready |=> vel_valid && $stable(vel))
		else $error("stalled result changed");

endmodule

bind pose_to_body_velocity_core ptbv_checker u_ptbv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pose_valid (pose_valid),
	.pose_ready (pose_ready),
	.pose       (pose),
	.vel_valid  (vel_valid),
	.vel_ready  (vel_ready),
	.vel        (vel)
);

[tb/tb_pose_to_body_velocity_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pose_to_body_velocity_core
// Drives timestamped poses into the core and checks every twist it returns
// against a bit-accurate twist predictor, or a typed-in twist for some table
// rows. A directed table comes first, followed by random pose trajectories
// under several interval settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_pose_to_body_velocity_core;
	import ptbv_pkg::*;

	localparam int    WATCHDOG_LIMIT = 20000;
	localparam int    SETTLE_CYCLES  = 300;
	localparam int    RANDOM_ITEMS   = 1130;
	localparam longint ONE_Q30       = 64'sd1073741824;

	logic        clk;
	logic        arst_n;
	logic        pose_valid;
	logic        pose_ready;
	pose_t       pose;
	logic        vel_valid;
	logic        vel_ready;
	twist_t      vel;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Per-request note: whether the twist is typed in, and its value.
	typedef struct {
		bit     typed;
		twist_t twist;
	} pose_note_t;

	pose_note_t note_q[$];
	twist_t     twist_q[$];
	int         errors;
	int         idle_cycles;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         recv_hold;

	// Predictor copy of the core state and registers.
	longint     min_ns, max_ns;
	bit         have_prev;
	logic [63:0] prev_stamp;
	longint     prev_pos[3];
	longint     prev_quat[4];

	// Generator state for well-formed trajectories.
	logic [63:0] gen_stamp;
	logic [31:0] gen_pos[3];

	pose_to_body_velocity_core uut (
		.clk(clk), .arst_n(arst_n),
		.pose_valid(pose_valid), .pose_ready(pose_ready), .pose(pose),
		.vel_valid(vel_valid), .vel_ready(vel_ready), .vel(vel),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	// Twist for one present pose; advances the predictor state.
	function automatic twist_t twist_from_pose(input pose_t p);
		twist_t t;
		longint pp[3], q[4], vw[3], r[9], dq[4], acc, dt, cw, cx, cy, cz;
		bit ok;
		t = '0;
		pp[0] = longint'(p.pos_x);
		pp[1] = longint'(p.pos_y);
		pp[2] = longint'(p.pos_z);
		q[0] = longint'(p.quat_x);
		q[1] = longint'(p.quat_y);
		q[2] = longint'(p.quat_z);
		q[3] = longint'(p.quat_w);
		ok = 1'b0;
		dt = 0;
		if (have_prev && p.stamp_ns >= prev_stamp) begin
			dt = longint'(p.stamp_ns - prev_stamp);
			ok = (p.stamp_ns - prev_stamp > 64'(min_ns)) && (p.stamp_ns - prev_stamp < 64'(max_ns));
		end
		if (ok) begin
			for (int i = 0; i < 3; i++)
				vw[i] = clamp32(((pp[i] - prev_pos[i]) * 64'sd1000000000) / dt);
			r[0] = ONE_Q30 - 2 * (qmul(q[1], q[1]) + qmul(q[2], q[2]));
			r[1] = 2 * (qmul(q[0], q[1]) - qmul(q[2], q[3]));
			r[2] = 2 * (qmul(q[0], q[2]) + qmul(q[1], q[3]));
			r[3] = 2 * (qmul(q[0], q[1]) + qmul(q[2], q[3]));
			r[4] = ONE_Q30 - 2 * (qmul(q[0], q[0]) + qmul(q[2], q[2]));
			r[5] = 2 * (qmul(q[1], q[2]) - qmul(q[0], q[3]));
			r[6] = 2 * (qmul(q[0], q[2]) - qmul(q[1], q[3]));
			r[7] = 2 * (qmul(q[1], q[2]) + qmul(q[0], q[3]));
			r[8] = ONE_Q30 - 2 * (qmul(q[0], q[0]) + qmul(q[1], q[1]));
			for (int i = 0; i < 9; i++)
				r[i] = clamp32(r[i]);
			// Body velocity is the transposed rotation applied to world velocity.
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += (r[k * 3 + c] * vw[k]) >>> 30;
				vw[c] = vw[c];
				case (c)
					0: t.lin_vel_x = 32'(clamp32(acc));
					1: t.lin_vel_y = 32'(clamp32(acc));
					default: t.lin_vel_z = 32'(clamp32(acc));
				endcase
			end
			// Rotation increment from the conjugate of the previous orientation.
			cw = prev_quat[3];
			cx = -prev_quat[0];
			cy = -prev_quat[1];
			cz = -prev_quat[2];
			dq[3] = qmul(cw, q[3]) - qmul(cx, q[0]) - qmul(cy, q[1]) - qmul(cz, q[2]);
			dq[0] = qmul(cw, q[0]) + qmul(cx, q[3]) + qmul(cy, q[2]) - qmul(cz, q[1]);
			dq[1] = qmul(cw, q[1]) - qmul(cx, q[2]) + qmul(cy, q[3]) + qmul(cz, q[0]);
			dq[2] = qmul(cw, q[2]) + qmul(cx, q[1]) - qmul(cy, q[0]) + qmul(cz, q[3]);
			if (dq[3] < 0) begin
				for (int i = 0; i < 3; i++)
					dq[i] = -dq[i];
			end
			t.ang_vel_x = 32'(clamp32((dq[0] * 64'sd1953125) / (dt * 16)));
			t.ang_vel_y = 32'(clamp32((dq[1] * 64'sd1953125) / (dt * 16)));
			t.ang_vel_z = 32'(clamp32((dq[2] * 64'sd1953125) / (dt * 16)));
			t.twist_valid = 1'b1;
		end
		for (int i = 0; i < 3; i++)
			prev_pos[i] = pp[i];
		for (int i = 0; i < 4; i++)
			prev_quat[i] = q[i];
		prev_stamp = p.stamp_ns;
		have_prev = 1'b1;
		return t;
	endfunction

	// Predict each accepted pose request.
	always @(posedge clk) begin
		pose_note_t n;
		twist_t t;
		if (pose_valid && pose_ready) begin
			n = note_q.pop_front();
			if (pose.body_present) begin
				t = twist_from_pose(pose);
				twist_q = {twist_q, (n.typed ? n.twist : t)};
			end
		end
	end

	// Check each accepted twist against the oldest expectation.
	always @(posedge clk) begin
		twist_t e;
		if (vel_valid && vel_ready) begin
			if (twist_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected twist %h", vel);
			end else begin
				e = twist_q.pop_front();
				if (vel.twist_valid !== e.twist_valid || vel.lin_vel_x !== e.lin_vel_x ||
						vel.lin_vel_y !== e.lin_vel_y || vel.lin_vel_z !== e.lin_vel_z ||
						vel.ang_vel_x !== e.ang_vel_x || vel.ang_vel_y !== e.ang_vel_y ||
						vel.ang_vel_z !== e.ang_vel_z) begin
					errors++;
					if (errors <= 10)
						$display("twist mismatch: expected %h actual %h", e, vel);
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			vel_ready <= 1'b0;
		end else if (recv_hold > 0) begin
			recv_hold--;
			vel_ready <= 1'b0;
		end else begin
			vel_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any accepted request.
	always @(posedge clk) begin
		if ((pose_valid && pose_ready) || (vel_valid && vel_ready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_pose_to_body_velocity_core: done, errors");
				$finish;
			end
		end
	end

	// Offer one pose request; valid is kept high into the next one when no gap follows.
	task automatic send_pose(input pose_t p, input bit typed, input twist_t t);
		pose_note_t n;
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			pose_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		n.typed = typed;
		n.twist = t;
		note_q = {note_q, n};
		pose <= p;
		pose_valid <= 1'b1;
		do @(posedge clk); while (!(pose_valid && pose_ready));
	endtask

	task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (a == 3'd0)
			min_ns = longint'(d);
		else if (a == 3'd4)
			max_ns = longint'(d);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Read back a register and compare it with the predictor copy.
	task automatic apb_check(input logic [2:0] a, input logic [31:0] want);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			errors++;
			if (errors <= 10)
				$display("register %0d: expected %h actual %h", a, want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Let the core finish all work before touching its registers.
	task automatic settle();
		pose_valid <= 1'b0;
		while (twist_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_intervals(input logic [31:0] lo, input logic [31:0] hi);
		settle();
		apb_write(3'd0, lo);
		apb_write(3'd4, hi);
		apb_check(3'd0, lo);
		apb_check(3'd4, hi);
	endtask

	function automatic pose_t mk_pose(input logic [63:0] s, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] w);
		pose_t p;
		p.body_present = 1'b1;
		p.stamp_ns = s;
		p.pos_x = x;
		p.pos_y = y;
		p.pos_z = z;
		p.quat_x = a;
		p.quat_y = b;
		p.quat_z = c;
		p.quat_w = w;
		return p;
	endfunction

	// Random pose: mostly a smooth trajectory with in-range steps, some noise.
	function automatic pose_t random_pose();
		pose_t p;
		logic [63:0] span, step;
		int kind;
		kind = $urandom_range(99);
		p = mk_pose({$urandom, $urandom}, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
		p.body_present = ($urandom_range(99) >= 4);
		if (kind < 80) begin
			span = (max_ns > min_ns + 2) ? 64'(max_ns - min_ns - 2) : 64'd0;
			if ($urandom_range(3) == 0)
				step = 64'(min_ns) + 1 + (span == 0 ? 0 : {$urandom, $urandom} % span);
			else
				step = 64'(min_ns) + 1 + (span == 0 ? 0 : 64'($urandom_range(3000000)) % span);
			p.stamp_ns = gen_stamp + step;
			for (int i = 0; i < 3; i++) begin
				if ($urandom_range(7) != 0)
					gen_pos[i] = gen_pos[i] + 32'($urandom_range(262144)) - 32'd131072;
				else
					gen_pos[i] = $urandom;
			end
			p.pos_x = gen_pos[0];
			p.pos_y = gen_pos[1];
			p.pos_z = gen_pos[2];
			if (kind < 60) begin
				p.quat_x = 32'($urandom_range(600000000)) - 32'd300000000;
				p.quat_y = 32'($urandom_range(600000000)) - 32'd300000000;
				p.quat_z = 32'($urandom_range(600000000)) - 32'd300000000;
				p.quat_w = ($urandom_range(1) ? 32'd1 : -32'sd1) *
					(32'd900000000 + 32'($urandom_range(173741824)));
			end
		end
		if (p.body_present)
			gen_stamp = p.stamp_ns;
		return p;
	endfunction

	typedef struct {
		pose_t  p;
		bit     typed;
		twist_t t;
	} table_row_t;

	table_row_t rows[$];

	task automatic add_row(input pose_t p, input bit typed, input twist_t t);
		table_row_t r;
		r.p = p;
		r.typed = typed;
		r.t = t;
		rows = {rows, r};
	endtask

	initial begin
		pose_t  p;
		twist_t zero_twist, still_twist;
		logic [31:0] one;
		int phase_items;
		logic [31:0] lo_set[5];
		logic [31:0] hi_set[5];
		int send_set[5];
		int recv_set[5];

		errors = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 0;
		arst_n = 1'b0;
		pose_valid = 1'b0;
		pose = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		min_ns = 100000;
		max_ns = 500000000;
		have_prev = 1'b0;
		prev_stamp = '0;
		for (int i = 0; i < 3; i++)
			prev_pos[i] = 0;
		for (int i = 0; i < 3; i++)
			prev_quat[i] = 0;
		prev_quat[3] = ONE_Q30;
		gen_stamp = '0;
		for (int i = 0; i < 3; i++)
			gen_pos[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers come out of reset at their documented values.
		apb_check(3'd0, MIN_RESET);
		apb_check(3'd4, MAX_RESET);

		zero_twist = '0;
		still_twist = '0;
		still_twist.twist_valid = 1'b1;
		one = 32'h4000_0000;

		// Directed table: first pose, bounds, time reversal, extremes.
		add_row(mk_pose(64'd1000000, 0, 0, 0, 0, 0, 0, one), 1, zero_twist);
		add_row(mk_pose(64'd2000000, 0, 0, 0, 0, 0, 0, one), 1, still_twist);
		p = mk_pose({$urandom, $urandom}, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
		p.body_present = 1'b0;
		add_row(p, 0, zero_twist);
		add_row(mk_pose(64'd2100000, 0, 0, 0, 0, 0, 0, one), 1, zero_twist);
		add_row(mk_pose(64'd2200001, 32'h0001_0000, 0, 0, 0, 0, 0, one), 0, zero_twist);
		add_row(mk_pose(64'd1000, 0, 0, 0, 0, 0, 0, one), 1, zero_twist);
		add_row(mk_pose(64'd500001000, 0, 0, 0, 0, 0, 0, one), 1, zero_twist);
		add_row(mk_pose(64'd1000000999, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			0, 0, 0, one), 0, zero_twist);
		add_row(mk_pose(64'd1001101000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			0, 0, 0, one), 0, zero_twist);
		add_row(mk_pose(64'd1001201001, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, zero_twist);
		add_row(mk_pose(64'd1001301002, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0, zero_twist);
		add_row(mk_pose(64'd1001401003, 32'h0, 32'h0, 32'h0001_0000,
			32'h1000_0000, 32'hf000_0000, 32'h0800_0000, 32'hc400_0000), 0, zero_twist);
		add_row(mk_pose(64'hffff_ffff_ffff_ffff, 0, 0, 0, 0, 0, 0, one), 1, zero_twist);
		add_row(mk_pose(64'd0, 0, 0, 0, 0, 0, 0, one), 1, zero_twist);
		add_row(mk_pose(64'd150000, 32'h0000_8000, 32'hffff_0000, 32'h0002_0000,
			0, 0, 32'h2d41_3ccd, 32'h2d41_3ccd), 0, zero_twist);
		add_row(mk_pose(64'd250001, 32'h0000_8000, 32'hffff_0000, 32'h0002_0000,
			0, 0, 32'h2d41_3ccd, 32'hd2be_c333), 0, zero_twist);
		foreach (rows[i])
			send_pose(rows[i].p, rows[i].typed, rows[i].t);

		// Put both bounds back to their reset values and read them back.
		settle();
		apb_write(3'd0, 32'd100000);
		apb_write(3'd4, 32'd500000000);
		apb_check(3'd0, 32'd100000);
		apb_check(3'd4, 32'd500000000);

		// Random phases: interval settings and idle patterns.
		lo_set = '{32'd0, 32'd1000, 32'd100000, 32'hffff_ffff, 32'd5000};
		hi_set = '{32'hffff_ffff, 32'd2000000, 32'd500000000, 32'd0, 32'd10000000};
		send_set = '{0, 65, 0, 20, 0};
		recv_set = '{0, 0, 65, 20, 0};
		gen_stamp = prev_stamp;
		for (int ph = 0; ph < 5; ph++) begin
			set_intervals(lo_set[ph], hi_set[ph]);
			send_idle_pct = send_set[ph];
			recv_stall_pct = recv_set[ph];
			phase_items = (ph == 3) ? RANDOM_ITEMS / 10 : RANDOM_ITEMS * 9 / 40;
			for (int k = 0; k < phase_items; k++) begin
				// Hold the receiver off long enough for the core to back up.
				if (ph == 4 && k == 10)
					recv_hold = 2000;
				send_pose(random_pose(), 0, zero_twist);
			end
		end

		settle();
		if (errors == 0 && twist_q.size() == 0) begin
			$display("tb_pose_to_body_velocity_core: done, clean");
		end else begin
			$display("tb_pose_to_body_velocity_core: done, errors");
		end
		$finish;
	end

endmodule

[files.f]
design/ptbv_pkg.sv
design/ptbv_regs.sv
design/ptbv_ctrl.sv
design/ptbv_div.sv
design/ptbv_dp.sv
design/pose_to_body_velocity_core.sv
design/ptbv_checker.sv
tb/tb_pose_to_body_velocity_core.sv
